// ----- design/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg - shared types and constants for the WebSocket frame deframer
// Result kinds, the item handed from the header parser to the output stage,
// and the decoupling queue geometry.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_EMPTY_END = 2'd1;
    localparam logic [1:0] KIND_ERROR     = 2'd2;

    // frame opcodes of interest
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // 7-bit length escapes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // decoupling queue
    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // item from parser to output stage; payload still masked
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] key;
        logic [3:0] opcode;
        logic       is_control;
        logic       frame_end;
        logic       message_end;
        logic       stream_closed;
    } wsd_item_t;

    // queue side toward the output stage
    typedef struct packed {
        logic      valid;
        wsd_item_t item;
    } wsd_qhead_t;

    function automatic logic is_control_op(input logic [3:0] op);
        return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

// ----- design/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer - WebSocket receive-side frame parser
// Parses frame headers from a byte stream and emits unmasked payload bytes,
// empty-frame markers and protocol errors, tagged with message state.
//
//   channel  dir  tdata                                   tuser / tlast
//   s_axis   in   [7:0] rx_byte                           -
//   m_axis   out  [7:0] payload_byte [11:8] msg_opcode    tuser [1:0] kind
//                 [12] message_end [13] stream_closed     [2] is_control
//                                                         tlast frame_end
//
// One byte per cycle while the queue is not full; a result passes through
// the queue storage and then the output register on its way to m_axis.
// A four-item queue sits between parser and output register, so s_axis
// stays ready while the sink stalls until the queue fills.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [11:8] msg_opcode,
                                        // [12] message_end, [13] stream_closed
    output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] is_control
    output logic        m_axis_tlast    // frame_end
);

    logic       push;
    wsd_item_t  push_item;
    logic       q_full;
    logic       pop;
    wsd_qhead_t head;

    wsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_axis_tvalid),
        .rx_byte    (s_axis_tdata),
        .q_full     (q_full),
        .byte_ready (s_axis_tready),
        .push       (push),
        .push_item  (push_item)
    );

    wsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .head      (head)
    );

    wsd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- design/wsd_front.sv -----
// ----------------------------------------------------------------------------
// wsd_front - header parser
// Walks the frame header one byte per cycle unless the queue is full,
// tracks message state and pushes a classified item per byte with a result.
// ----------------------------------------------------------------------------
module wsd_front import wsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    input  logic       q_full,
    output logic       byte_ready,
    output logic       push,
    output wsd_item_t  push_item
);

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT     = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  opc_reg, opc_next;
    logic        fin_reg, fin_next;
    logic        masked_reg, masked_next;
    logic [63:0] rem_reg, rem_next;
    logic [2:0]  ext_reg, ext_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  idx_reg, idx_next;
    logic        in_msg_reg, in_msg_next;
    logic [3:0]  msg_op_reg, msg_op_next;
    logic        closed_reg, closed_next;

    logic        accept;
    logic        len_known;
    logic        do_start;
    logic        do_finish;
    logic [1:0]  fin_kind;
    logic [7:0]  fin_data;
    logic [7:0]  fin_key;
    logic [7:0]  key_byte;
    logic        ctrl;

    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;
    assign ctrl       = is_control_op(opc_reg);

    // key byte for the current rotation
    always_comb begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // parser next state and result classification
    always_comb begin
        phase_next  = phase_reg;
        opc_next    = opc_reg;
        fin_next    = fin_reg;
        masked_next = masked_reg;
        rem_next    = rem_reg;
        ext_next    = ext_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        in_msg_next = in_msg_reg;
        msg_op_next = msg_op_reg;
        closed_next = closed_reg;
        len_known   = 1'b0;
        do_start    = 1'b0;
        do_finish   = 1'b0;
        fin_kind    = KIND_EMPTY_END;
        fin_data    = '0;
        fin_key     = '0;
        push        = 1'b0;
        push_item   = '0;

        if (accept && !closed_reg) begin
            case (phase_reg)
                PH_HDR0: begin
                    fin_next   = rx_byte[7];
                    opc_next   = rx_byte[3:0];
                    phase_next = PH_HDR1;
                end
                PH_HDR1: begin
                    masked_next = rx_byte[7];
                    rem_next    = '0;
                    if (rx_byte[6:0] == LEN_EXT16) begin
                        ext_next   = 3'd2;
                        phase_next = PH_EXT;
                    end else if (rx_byte[6:0] == LEN_EXT64) begin
                        ext_next   = 3'd0;   // eight bytes, wraps through zero
                        phase_next = PH_EXT;
                    end else begin
                        rem_next  = {57'd0, rx_byte[6:0]};
                        len_known = 1'b1;
                    end
                end
                PH_EXT: begin
                    rem_next = {rem_reg[55:0], rx_byte};
                    ext_next = ext_reg - 3'd1;
                    if (ext_next == 3'd0) begin
                        len_known = 1'b1;
                    end
                end
                PH_MASK: begin
                    key_next = {key_reg[23:0], rx_byte};
                    idx_next = idx_reg + 2'd1;
                    if (idx_next == 2'd0) begin
                        do_start = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    idx_next = idx_reg + 2'd1;
                    rem_next = rem_reg - 64'd1;
                    if (rem_next == 64'd0) begin
                        do_finish = 1'b1;
                        fin_kind  = KIND_PAYLOAD;
                        fin_data  = rx_byte;
                        fin_key   = masked_reg ? key_byte : 8'd0;
                    end else begin
                        push                 = 1'b1;
                        push_item.kind       = KIND_PAYLOAD;
                        push_item.data       = rx_byte;
                        push_item.key        = masked_reg ? key_byte : 8'd0;
                        push_item.opcode     = ctrl ? opc_reg : msg_op_reg;
                        push_item.is_control = ctrl;
                    end
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase

            // length complete: collect the key or open the frame
            if (len_known) begin
                if (masked_next) begin
                    key_next   = '0;
                    idx_next   = '0;
                    phase_next = PH_MASK;
                end else begin
                    do_start = 1'b1;
                end
            end

            // frame open
            if (do_start) begin
                idx_next = '0;
                if (!ctrl && (opc_reg == OP_CONT) && !in_msg_reg) begin
                    // continuation with no message open
                    closed_next             = 1'b1;
                    phase_next              = PH_HDR0;
                    push                    = 1'b1;
                    push_item.kind          = KIND_ERROR;
                    push_item.stream_closed = 1'b1;
                end else begin
                    if (!ctrl && (opc_reg != OP_CONT)) begin
                        msg_op_next = opc_reg;
                        in_msg_next = 1'b1;
                    end
                    if (rem_next == 64'd0) begin
                        do_finish = 1'b1;
                        fin_kind  = KIND_EMPTY_END;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end

            // frame close
            if (do_finish) begin
                if (!ctrl && fin_reg) begin
                    in_msg_next = 1'b0;
                end
                if (opc_reg == OP_CLOSE) begin
                    closed_next = 1'b1;
                end
                phase_next              = PH_HDR0;
                push                    = 1'b1;
                push_item.kind          = fin_kind;
                push_item.data          = fin_data;
                push_item.key           = fin_key;
                push_item.opcode        = ctrl ? opc_reg : msg_op_next;
                push_item.is_control    = ctrl;
                push_item.frame_end     = 1'b1;
                push_item.message_end   = ctrl || fin_reg;
                push_item.stream_closed = (opc_reg == OP_CLOSE);
            end
        end
    end

    // parser registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            opc_reg    <= '0;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
            rem_reg    <= '0;
            ext_reg    <= '0;
            key_reg    <= '0;
            idx_reg    <= '0;
            in_msg_reg <= 1'b0;
            msg_op_reg <= '0;
            closed_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            opc_reg    <= opc_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
            rem_reg    <= rem_next;
            ext_reg    <= ext_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
            in_msg_reg <= in_msg_next;
            msg_op_reg <= msg_op_next;
            closed_reg <= closed_next;
        end
    end

`ifndef SYNTHESIS
    // a closed stream stays closed
    a_closed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        closed_reg |=> closed_reg)
        else $error("stream reopened after close");

    // nothing comes out of a closed stream
    a_no_push_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        closed_reg |-> !push)
        else $error("item pushed on closed stream");

    // a closing item really closes the stream
    a_close_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_item.stream_closed) |=> closed_reg)
        else $error("stream_closed item without closing");
`endif

endmodule

// ----- design/wsd_queue.sv -----
// ----------------------------------------------------------------------------
// wsd_queue - decoupling queue
// Small register FIFO between the parser and the output stage so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module wsd_queue import wsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  wsd_item_t  push_item,
    input  logic       pop,
    output logic       full,
    output wsd_qhead_t head
);

    wsd_item_t         mem_reg [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    // the parser never pushes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue overflow");

    // fill count bounded by depth
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ----- design/wsd_back.sv -----
// ----------------------------------------------------------------------------
// wsd_back - output stage
// Unmasks the payload byte and holds the result in an output register
// until the sink takes it.
// ----------------------------------------------------------------------------
module wsd_back import wsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  wsd_qhead_t  head,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic       valid_reg, valid_next;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic [3:0] op_reg;
    logic       ctrl_reg;
    logic       fend_reg;
    logic       mend_reg;
    logic       closed_reg;

    // load when the output register is free or being drained
    assign pop = head.valid && (!valid_reg || m_axis_tready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result payload, key applied here
    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg   <= head.item.kind;
            byte_reg   <= head.item.data ^ head.item.key;
            op_reg     <= head.item.opcode;
            ctrl_reg   <= head.item.is_control;
            fend_reg   <= head.item.frame_end;
            mend_reg   <= head.item.message_end;
            closed_reg <= head.item.stream_closed;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {2'b00, closed_reg, mend_reg, op_reg, byte_reg};
    assign m_axis_tuser  = {ctrl_reg, kind_reg};
    assign m_axis_tlast  = fend_reg;

`ifndef SYNTHESIS
    // non-payload results carry no byte
    a_nonpayload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser[1:0] != KIND_PAYLOAD)) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("byte on non-payload result");
`endif

endmodule
